### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the blink-rate control RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle implication, same clock and reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/core/dbrc_pkg.sv
// ----------------------------------------------------------------------------
// dbrc_pkg
// Types, register indexes and reset values for the blink-rate control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dbrc_pkg;

	localparam int NUM_LEVELS_DEF  = 7;
	localparam int INIT_LEVEL_DEF  = 2;
	localparam int TIME_BITS_DEF   = 32;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 4;
	localparam int NUM_HALF  = 7;
	localparam int HALF_IDX_W = 3;
	localparam int LEVEL_W   = 3;
	localparam int TS_W      = 32;

	typedef logic [CFG_W-1:0]     cfg_word_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [NUM_HALF-1:0][CFG_W-1:0] half_tab_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 4'd0,
		REG_HALF0    = 4'd1,
		REG_HALF6    = 4'd7
	} reg_idx_t;

	localparam cfg_word_t DEBOUNCE_RESET = 16'd50;
	localparam half_tab_t HALF_RESET = {
		16'd50, 16'd100, 16'd200, 16'd300, 16'd500, 16'd700, 16'd1000
	};

	typedef struct packed {
		logic            faster_pressed;
		logic            slower_pressed;
		logic [TS_W-1:0] timestamp_ms;
	} sample_t;

	typedef struct packed {
		logic   led_lit;
		level_t speed_level;
		logic   level_changed;
		logic   led_toggled;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/debounced_blink_rate_control_unit.sv
// ----------------------------------------------------------------------------
// debounced_blink_rate_control_unit
// Takes one sample per cycle, when not stalled, of two buttons and a
// millisecond timestamp and returns one result per sample: LED drive, speed
// level and change flags. A sample is registered on transfer, evaluated
// against the button, level and LED state and written to the result
// register once that is free, so a new sample can transfer on every cycle
// unless a result stalls. The result register lets the next sample transfer
// while a result waits. Configuration writes are always ready and take effect
// at once, so they belong in gaps where no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_blink_rate_control_unit #(
	parameter int NUM_LEVELS  = dbrc_pkg::NUM_LEVELS_DEF,
	parameter int INIT_LEVEL  = dbrc_pkg::INIT_LEVEL_DEF,
	parameter int TIME_BITS   = dbrc_pkg::TIME_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	input  wire dbrc_pkg::sample_t   sample,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output dbrc_pkg::result_t        result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire dbrc_pkg::cfg_idx_t  cfg_index,
	input  wire dbrc_pkg::cfg_word_t cfg_data
);

	`include "assert_macros.svh"

	localparam int TOP_INT   = NUM_LEVELS - 1;
	localparam int START_INT = (INIT_LEVEL > TOP_INT) ? TOP_INT : INIT_LEVEL;
	localparam dbrc_pkg::level_t TOP   = dbrc_pkg::level_t'(TOP_INT);
	localparam dbrc_pkg::level_t START = dbrc_pkg::level_t'(START_INT);

	dbrc_pkg::cfg_word_t debounce;
	dbrc_pkg::half_tab_t half_period;

	logic              s1_valid_s1;
	dbrc_pkg::sample_t sample_s1;
	logic              s2_valid_s2;
	dbrc_pkg::result_t result_s2;
	logic              advance;

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] toggle_ref;
	logic [TIME_BITS-1:0] toggle_elapsed;
	logic                 up;
	logic                 down;
	dbrc_pkg::level_t     level_up;
	dbrc_pkg::level_t     level_nxt;
	dbrc_pkg::cfg_word_t  half;
	logic                 toggle;

	dbrc_pkg::level_t     level_q;
	logic                 led_q;
	logic                 started_q;
	logic [TIME_BITS-1:0] toggle_time_q;

	assign cfg_ready = 1'b1;

	dbrc_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.debounce    (debounce),
		.half_period (half_period)
	);

	// pipeline control
	assign advance      = s1_valid_s1 && (!s2_valid_s2 || !result_stall);
	assign sample_stall = s1_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (sample_valid && !sample_stall) begin
			s1_valid_s1 <= 1'b1;
		end else if (advance) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	assign now = TIME_BITS'(sample_s1.timestamp_ms);

	dbrc_button #(.TIME_BITS(TIME_BITS)) u_faster (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.pressed  (sample_s1.faster_pressed),
		.now      (now),
		.debounce (debounce),
		.counted  (up)
	);

	dbrc_button #(.TIME_BITS(TIME_BITS)) u_slower (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.pressed  (sample_s1.slower_pressed),
		.now      (now),
		.debounce (debounce),
		.counted  (down)
	);

	// raise first, then lower
	always_comb begin
		level_up  = (up && (level_q < TOP)) ? level_q + 1'b1 : level_q;
		level_nxt = (down && (level_up != '0)) ? level_up - 1'b1 : level_up;
	end

	assign half           = half_period[level_nxt];
	assign toggle_ref     = started_q ? toggle_time_q : now;
	assign toggle_elapsed = now - toggle_ref;
	assign toggle         = toggle_elapsed >= TIME_BITS'(half);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= START;
			led_q     <= 1'b0;
			started_q <= 1'b0;
		end else if (advance) begin
			level_q   <= level_nxt;
			led_q     <= led_q ^ toggle;
			started_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			toggle_time_q <= toggle ? now : toggle_ref;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (advance) begin
			s2_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			s2_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.led_lit       <= led_q ^ toggle;
			result_s2.speed_level   <= level_nxt;
			result_s2.level_changed <= level_nxt != level_q;
			result_s2.led_toggled   <= toggle;
		end
	end

	assign result_valid = s2_valid_s2;
	assign result       = result_s2;

	`ASSERT_CLK(a_level_in_range, level_q <= TOP, "speed level above top")
	`ASSERT_NEXT(a_adv_gives_result, advance, s2_valid_s2, "evaluated sample lost")
	`ASSERT_NEXT(a_toggle_flag, advance,
		result_s2.led_toggled == (result_s2.led_lit != $past(led_q)),
		"toggle flag disagrees with LED")
	`ASSERT_NEXT(a_change_flag, advance,
		result_s2.level_changed == (result_s2.speed_level != $past(level_q)),
		"level change flag disagrees with level")
	`ASSERT_CLK(a_stall_needs_item, !sample_stall || s1_valid_s1,
		"input stalled with empty stage")

endmodule

`default_nettype wire

### rtl/core/dbrc_cfg.sv
// ----------------------------------------------------------------------------
// dbrc_cfg
// Configuration registers: debounce time and per-level LED half periods.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrc_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire dbrc_pkg::cfg_idx_t  cfg_index,
	input  wire dbrc_pkg::cfg_word_t cfg_data,
	output dbrc_pkg::cfg_word_t      debounce,
	output dbrc_pkg::half_tab_t      half_period
);

	dbrc_pkg::cfg_word_t debounce_q;
	dbrc_pkg::half_tab_t half_q;
	dbrc_pkg::cfg_idx_t  half_off;
	logic                half_sel;

	assign half_off = cfg_index - dbrc_pkg::REG_HALF0;
	assign half_sel = (cfg_index >= dbrc_pkg::REG_HALF0) && (cfg_index <= dbrc_pkg::REG_HALF6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= dbrc_pkg::DEBOUNCE_RESET;
			half_q     <= dbrc_pkg::HALF_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == dbrc_pkg::REG_DEBOUNCE) begin
				debounce_q <= cfg_data;
			end else if (half_sel) begin
				half_q[half_off[dbrc_pkg::HALF_IDX_W-1:0]] <= cfg_data;
			end
		end
	end

	assign debounce    = debounce_q;
	assign half_period = half_q;

endmodule

`default_nettype wire

### rtl/core/dbrc_button.sv
// ----------------------------------------------------------------------------
// dbrc_button
// Per-button change tracking and debounced press-edge detection.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrc_button #(
	parameter int TIME_BITS = dbrc_pkg::TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 pressed,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire dbrc_pkg::cfg_word_t  debounce,
	output logic                      counted
);

	logic                 prev_q;
	logic                 seen_q;
	logic [TIME_BITS-1:0] change_time_q;
	logic [TIME_BITS-1:0] elapsed;
	logic                 changed;

	assign changed = pressed != prev_q;
	assign elapsed = now - change_time_q;
	assign counted = changed && pressed &&
		(!seen_q || (elapsed >= TIME_BITS'(debounce)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			seen_q <= 1'b0;
		end else if (en && changed) begin
			prev_q <= pressed;
			seen_q <= 1'b1;
		end
	end

	// change time is only read once seen_q is set
	always_ff @(posedge clk) begin
		if (en && changed) begin
			change_time_q <= now;
		end
	end

endmodule

`default_nettype wire

### tb/debounced_blink_rate_control_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_blink_rate_control_unit_tb
// Self-checking bench for the blink-rate control unit. A directed table covers
// reset, debounce, level saturation at both ends, both buttons at once and
// timestamp wrap. Random button traffic then runs under zero, full-scale and
// random register settings. A local predictor gives all untyped results, and
// handshake gaps and stalls are randomized on both sides in phases 0 to 4.
// ----------------------------------------------------------------------------

module debounced_blink_rate_control_unit_tb;

	import dbrc_pkg::*;

	localparam int DIRECTED_ROWS   = 27;
	localparam int ITEMS_PER_PHASE = 208;
	localparam int NUM_PHASES      = 7;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_CYCLES     = 80;
	localparam int MAX_REPORTS     = 10;
	localparam int FASTER          = 0;
	localparam int SLOWER          = 1;

	typedef enum {SET_ZERO, SET_FULL, SET_RANDOM} reg_set_t;

	typedef struct packed {
		sample_t stim;
		logic    typed;
		result_t want;
	} dir_row_t;

	// typed rows: {led_lit, speed_level, level_changed, led_toggled}
	localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
		{1'b1, 1'b1, 32'd0,          1'b1, 1'b0, 3'd2, 1'b0, 1'b0}, // held at reset
		{1'b0, 1'b0, 32'd10,         1'b0, 6'd0},
		{1'b1, 1'b0, 32'd100,        1'b1, 1'b0, 3'd3, 1'b1, 1'b0},
		{1'b0, 1'b0, 32'd120,        1'b0, 6'd0},
		{1'b1, 1'b0, 32'd200,        1'b0, 6'd0},
		{1'b0, 1'b0, 32'd260,        1'b0, 6'd0},
		{1'b1, 1'b0, 32'd320,        1'b0, 6'd0},
		{1'b0, 1'b0, 32'd380,        1'b0, 6'd0},
		{1'b1, 1'b0, 32'd440,        1'b0, 6'd0},
		{1'b0, 1'b0, 32'd500,        1'b0, 6'd0},
		{1'b1, 1'b0, 32'd560,        1'b1, 1'b1, 3'd6, 1'b0, 1'b1}, // top saturates
		{1'b0, 1'b0, 32'd570,        1'b0, 6'd0},
		{1'b1, 1'b0, 32'd580,        1'b0, 6'd0},                   // bounce
		{1'b0, 1'b0, 32'd700,        1'b0, 6'd0},
		{1'b1, 1'b1, 32'd800,        1'b0, 6'd0},                   // both pressed
		{1'b0, 1'b0, 32'd900,        1'b0, 6'd0},
		{1'b0, 1'b1, 32'd1000,       1'b0, 6'd0},
		{1'b0, 1'b0, 32'd1100,       1'b0, 6'd0},
		{1'b0, 1'b1, 32'd1200,       1'b0, 6'd0},
		{1'b0, 1'b0, 32'd1300,       1'b0, 6'd0},
		{1'b0, 1'b1, 32'd1400,       1'b0, 6'd0},
		{1'b0, 1'b0, 32'hFFFF_FFC0,  1'b0, 6'd0},
		{1'b0, 1'b1, 32'h0000_0010,  1'b0, 6'd0},                   // wrap
		{1'b0, 1'b0, 32'h0000_0100,  1'b0, 6'd0},
		{1'b0, 1'b1, 32'hFFFF_FFFF,  1'b0, 6'd0},
		{1'b0, 1'b0, 32'h0000_0000,  1'b0, 6'd0},
		{1'b0, 1'b1, 32'h0000_0040,  1'b0, 6'd0}                    // bottom saturates
	};

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      sample_valid = 1'b0;
	sample_t   sample       = '0;
	logic      result_stall = 1'b0;
	logic      cfg_valid    = 1'b0;
	cfg_idx_t  cfg_index    = '0;
	cfg_word_t cfg_data     = '0;
	wire logic sample_stall;
	wire logic result_valid;
	wire logic cfg_ready;
	result_t   result;

	debounced_blink_rate_control_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cfg_word_t       debounce_ms_q;
	cfg_word_t       half_period_q [NUM_HALF];
	logic            btn_prev      [2];
	logic            btn_seen      [2];
	logic [TS_W-1:0] btn_change_ts [2];
	level_t          level_q;
	logic            led_q;
	logic [TS_W-1:0] toggle_ts;
	logic            started_q;

	result_t expected_results [$];
	result_t checker_want;

	int tx_idle_pct;
	int rx_stall_pct;
	int phase_no;
	int hold_left;
	bit held;
	int cycle_count;
	int errors;
	int items_sent;
	int results_checked;
	int level_changes_seen;
	int toggles_seen;
	int cfg_writes;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void reset_blink_model();
		debounce_ms_q = DEBOUNCE_RESET;
		for (int i = 0; i < NUM_HALF; i++)
			half_period_q[i] = HALF_RESET[i];
		for (int b = 0; b < 2; b++) begin
			btn_prev[b]      = 1'b1;
			btn_seen[b]      = 1'b0;
			btn_change_ts[b] = '0;
		end
		level_q   = level_t'(INIT_LEVEL_DEF);
		led_q     = 1'b0;
		toggle_ts = '0;
		started_q = 1'b0;
	endfunction

	function automatic logic press_counted(int b, logic lvl, logic [TS_W-1:0] now);
		logic            counted;
		logic [TS_W-1:0] elapsed;
		counted = 1'b0;
		if (lvl != btn_prev[b]) begin
			elapsed = now - btn_change_ts[b];
			counted = lvl && (!btn_seen[b] || elapsed >= TS_W'(debounce_ms_q));
			btn_change_ts[b] = now;
			btn_seen[b]      = 1'b1;
			btn_prev[b]      = lvl;
		end
		return counted;
	endfunction

	function automatic result_t predict_blink(sample_t s);
		result_t         r;
		level_t          level_before;
		logic            up;
		logic            down;
		logic [TS_W-1:0] now;
		logic [TS_W-1:0] elapsed;
		now          = s.timestamp_ms;
		level_before = level_q;
		up           = press_counted(FASTER, s.faster_pressed, now);
		down         = press_counted(SLOWER, s.slower_pressed, now);
		if (up && level_q < NUM_LEVELS_DEF - 1)
			level_q = level_q + 1'b1;
		if (down && level_q > 0)
			level_q = level_q - 1'b1;
		if (!started_q) begin
			toggle_ts = now;
			started_q = 1'b1;
		end
		elapsed       = now - toggle_ts;
		r.led_toggled = 1'b0;
		if (elapsed >= TS_W'(half_period_q[level_q])) begin
			led_q         = ~led_q;
			toggle_ts     = now;
			r.led_toggled = 1'b1;
		end
		r.led_lit       = led_q;
		r.speed_level   = level_q;
		r.level_changed = (level_q != level_before);
		return r;
	endfunction

	function automatic void apply_reg_write(cfg_idx_t idx, cfg_word_t d);
		if (idx == REG_DEBOUNCE)
			debounce_ms_q = d;
		else if (idx >= REG_HALF0 && idx <= REG_HALF6)
			half_period_q[idx - REG_HALF0] = d;
	endfunction

	task automatic write_reg(cfg_idx_t idx, cfg_word_t d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, d);
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic configure(reg_set_t set);
		cfg_word_t d;
		cfg_idx_t  idx;
		for (int i = 0; i <= REG_HALF6; i++) begin
			idx = (i == 0) ? cfg_idx_t'(REG_DEBOUNCE) : cfg_idx_t'(REG_HALF0 + i - 1);
			case (set)
				SET_ZERO: d = '0;
				SET_FULL: d = '1;
				default: d = (i == 0) ? cfg_word_t'($urandom_range(0, 120))
					: cfg_word_t'($urandom_range(0, 600));
			endcase
			write_reg(idx, d);
		end
		// indexes past the last register must be ignored
		write_reg(cfg_idx_t'($urandom_range(int'(REG_HALF6) + 1, (1 << CFG_IDX_W) - 1)),
			cfg_word_t'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic transfer_sample(sample_t s, logic typed, result_t want);
		result_t r;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (sample_stall);
		r = predict_blink(s);
		expected_results.push_back(typed ? want : r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idling(int p);
		if (p < 3) begin
			tx_idle_pct  = 8;
			rx_stall_pct = 54;
		end else if (p < 5) begin
			tx_idle_pct  = 54;
			rx_stall_pct = 8;
		end else begin
			tx_idle_pct  = 0;
			rx_stall_pct = 0;
		end
	endtask

	// result side: random stall, plus one long hold-off to back up the pipe
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (phase_no == 5 && !held && result_valid) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result transfer with nothing expected: %p", $realtime, result);
			end else begin
				checker_want = expected_results.pop_front();
				results_checked++;
				if (result.led_lit !== checker_want.led_lit
						|| result.speed_level !== checker_want.speed_level
						|| result.level_changed !== checker_want.level_changed
						|| result.led_toggled !== checker_want.led_toggled) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: exp/got led %0b/%0b lvl %0d/%0d chg %0b/%0b tgl %0b/%0b",
							$realtime,
							checker_want.led_lit, result.led_lit,
							checker_want.speed_level, result.speed_level,
							checker_want.level_changed, result.level_changed,
							checker_want.led_toggled, result.led_toggled);
				end
			end
			if (result.level_changed === 1'b1)
				level_changes_seen++;
			if (result.led_toggled === 1'b1)
				toggles_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL debounced_blink_rate_control_unit");
			$finish;
		end
	end

	initial begin
		sample_t         s;
		logic            f;
		logic            sl;
		logic [TS_W-1:0] ts;
		reset_blink_model();
		phase_no = 0;
		set_idling(0);
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			transfer_sample(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);

		for (int p = 1; p < NUM_PHASES; p++) begin
			sample_valid <= 1'b0;
			wait_drained();
			phase_no = p;
			set_idling(p);
			configure(p == 1 ? SET_ZERO : p == 2 ? SET_FULL : SET_RANDOM);
			f  = $urandom_range(0, 1);
			sl = $urandom_range(0, 1);
			ts = $urandom;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					// chatter on both buttons
					f  = $urandom_range(0, 1);
					sl = $urandom_range(0, 1);
				end else begin
					if ($urandom_range(0, 3) == 0)
						f = ~f;
					if ($urandom_range(0, 4) == 0)
						sl = ~sl;
				end
				if ($urandom_range(0, 39) == 0)
					ts = $urandom;
				else
					ts = ts + $urandom_range(0, 40);
				s.faster_pressed = f;
				s.slower_pressed = sl;
				s.timestamp_ms   = ts;
				transfer_sample(s, 1'b0, '0);
			end
		end

		sample_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d samples over %0d register settings, %0d results checked",
			items_sent, NUM_PHASES, results_checked);
		$display("%0d level changes, %0d LED toggles, %0d register writes, %0d errors",
			level_changes_seen, toggles_seen, cfg_writes, errors);
		if (errors == 0)
			$display("PASS debounced_blink_rate_control_unit");
		else
			$display("FAIL debounced_blink_rate_control_unit");
		$finish;
	end

endmodule
